>>> sv/ofifo_pkg.sv
// shared types, constants and helpers for the overwriting ring fifo
// used by every module of the block but the ram
`default_nettype none

package ofifo_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 2;
    localparam int COUNT_W     = 5;
    localparam int STATUS_W    = 2;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int N_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int RD_LIMIT = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
    localparam int BURST_W = $clog2(RD_LIMIT + 1);

    // output queue sizing
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_LVL_W = $clog2(OQ_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RDL  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERWRITE = 2'd2;

    // result slot issued by the controller, registered so that it lines up with the ram read data
    typedef struct packed {
        logic                valid;
        logic                use_ram;
        logic [STATUS_W-1:0] status;
        logic                last;
    } issue_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } res_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

>>> sv/ofifo_ram.sv
// simple dual port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module ofifo_ram #(
    parameter int WIDTH = 32,
    parameter int WORDS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(WORDS)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(WORDS)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/ofifo_outq.sv
// small result queue that decouples the output handshake from the controller
// depends on ofifo_pkg
`default_nettype none

module ofifo_outq
    import ofifo_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  res_t                     push_res,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output res_t                     out_res,
    output logic [OQ_LVL_W-1:0]      level
);

    res_t                slot [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wp_reg, wp_next;
    logic [OQ_PTR_W-1:0] rp_reg, rp_next;
    logic [OQ_LVL_W-1:0] lvl_reg, lvl_next;
    logic                pop;

    assign out_valid = (lvl_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_res   = slot[rp_reg];
    assign level     = lvl_reg;

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        lvl_next = lvl_reg;
        if (push && !pop)
        begin
            lvl_next = lvl_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            lvl_next = lvl_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            lvl_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            lvl_reg <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wp_reg] <= push_res;
        end
    end

    // credit check upstream must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (lvl_reg < OQ_LVL_W'(OQ_DEPTH)))
        else $error("result queue overflow");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= OQ_LVL_W'(OQ_DEPTH))
        else $error("result queue level out of range");

endmodule

`default_nettype wire

>>> sv/ofifo_ctrl.sv
// command sequencer: pointers, fill count and read-last burst walk
// depends on ofifo_pkg, drives the entry ram
`default_nettype none

module ofifo_ctrl
    import ofifo_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [CMD_W-1:0]    cmd,
    input  wire logic [COUNT_W-1:0]  count,
    input  wire logic                room,
    output logic                     ram_we,
    output logic [PTR_W-1:0]         ram_waddr,
    output logic [PTR_W-1:0]         ram_raddr,
    output issue_t                   issue
);

    typedef enum logic {S_IDLE, S_BURST} state_t;

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    rd_reg, rd_next;
    logic [PTR_W-1:0]    wr_reg, wr_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [PTR_W-1:0]    idx_reg, idx_next;
    logic [BURST_W-1:0]  rem_reg, rem_next;
    issue_t              issue_reg, issue_next;

    logic                accept;
    logic [N_W-1:0]      cnt_lim, n_sel;
    logic [CNT_W:0]      start_sum;
    logic [PTR_W-1:0]    start_idx;
    logic [CNT_W:0]      chk_sum;
    logic [PTR_W-1:0]    chk_wr;

    assign in_ready = (state_reg == S_IDLE) && room;
    assign accept   = in_valid && in_ready;
    assign issue    = issue_reg;

    // n = min(count, limit, fill)
    always_comb
    begin
        cnt_lim = (N_W'(count) > N_W'(RD_LIMIT)) ? N_W'(RD_LIMIT) : N_W'(count);
        n_sel   = (cnt_lim > N_W'(fill_reg)) ? N_W'(fill_reg) : cnt_lim;
    end

    // oldest of the newest n entries, sum stays below twice the depth
    assign start_sum = {1'b0, CNT_W'(rd_reg)} + {1'b0, fill_reg - CNT_W'(n_sel)};
    assign start_idx = (start_sum >= (CNT_W + 1)'(DEPTH)) ?
                       PTR_W'(start_sum - (CNT_W + 1)'(DEPTH)) : PTR_W'(start_sum);

    // a read and a write never go out in the same cycle, and the ram write
    // lands before any later read, so no forwarding is needed
    always_comb
    begin
        state_next = state_reg;
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        issue_next = '0;
        ram_we     = 1'b0;
        ram_waddr  = wr_reg;
        ram_raddr  = rd_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_ENQ:
                        begin
                            ram_we            = 1'b1;
                            wr_next           = ptr_inc(wr_reg);
                            issue_next.valid  = 1'b1;
                            issue_next.last   = 1'b1;
                            if (fill_reg == CNT_W'(DEPTH))
                            begin
                                rd_next           = ptr_inc(rd_reg);
                                issue_next.status = ST_OVERWRITE;
                            end
                            else
                            begin
                                fill_next         = fill_reg + 1'b1;
                                issue_next.status = ST_OK;
                            end
                        end
                        CMD_DEQ:
                        begin
                            issue_next.valid = 1'b1;
                            issue_next.last  = 1'b1;
                            if (fill_reg == '0)
                            begin
                                issue_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                issue_next.use_ram = 1'b1;
                                issue_next.status  = ST_OK;
                                rd_next            = ptr_inc(rd_reg);
                                fill_next          = fill_reg - 1'b1;
                            end
                        end
                        CMD_RDL:
                        begin
                            issue_next.valid = 1'b1;
                            if (n_sel == '0)
                            begin
                                issue_next.status = ST_EMPTY;
                                issue_next.last   = 1'b1;
                            end
                            else
                            begin
                                ram_raddr          = start_idx;
                                issue_next.use_ram = 1'b1;
                                issue_next.status  = ST_OK;
                                issue_next.last    = (n_sel == N_W'(1));
                                idx_next           = ptr_inc(start_idx);
                                rem_next           = BURST_W'(n_sel - N_W'(1));
                                if (n_sel != N_W'(1))
                                begin
                                    state_next = S_BURST;
                                end
                            end
                        end
                        default:
                        begin
                            // unused command, dropped without a result
                        end
                    endcase
                end
            end
            S_BURST:
            begin
                ram_raddr = idx_reg;
                if (room)
                begin
                    issue_next.valid   = 1'b1;
                    issue_next.use_ram = 1'b1;
                    issue_next.status  = ST_OK;
                    issue_next.last    = (rem_reg == BURST_W'(1));
                    idx_next           = ptr_inc(idx_reg);
                    rem_next           = rem_reg - 1'b1;
                    if (rem_reg == BURST_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rd_reg    <= '0;
            wr_reg    <= '0;
            fill_reg  <= '0;
            idx_reg   <= '0;
            rem_reg   <= '0;
            issue_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
            issue_reg <= issue_next;
        end
    end

    // write pointer always sits fill entries past the read pointer
    assign chk_sum = {1'b0, CNT_W'(rd_reg)} + {1'b0, fill_reg};
    assign chk_wr  = (chk_sum >= (CNT_W + 1)'(DEPTH)) ?
                     PTR_W'(chk_sum - (CNT_W + 1)'(DEPTH)) : PTR_W'(chk_sum);

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg == chk_wr)
        else $error("write pointer out of step with read pointer and fill");

    a_burst_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BURST) |-> (rem_reg != '0))
        else $error("burst state with no words left");

endmodule

`default_nettype wire

>>> sv/overwriting_ring_fifo_top.sv
// overwriting ring fifo: enqueue and dequeue leave the controller free for
// the next command, each result word passes through the issue register into
// the result queue before it is offered; read-last issues its words in turn
// through the one ram read port and takes the next command after the last
// read is issued, all held back by a credit check on the four-word queue
// reset clears pointers, fill count and the result queue, not the entry store
`default_nettype none

module overwriting_ring_fifo_top
    import ofifo_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [CMD_W-1:0]         cmd,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic [COUNT_W-1:0]       count,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      data,
    output logic [STATUS_W-1:0]           status,
    output logic                          last
);

    logic                ram_we;
    logic [PTR_W-1:0]    ram_waddr;
    logic [PTR_W-1:0]    ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    issue_t              issue;
    logic [OQ_LVL_W-1:0] level;
    logic                room;
    res_t                push_res;
    res_t                out_res;

    // words already queued plus the one being pushed from the issue register
    assign room = ({1'b0, level} + {{OQ_LVL_W{1'b0}}, issue.valid})
                  < (OQ_LVL_W + 1)'(OQ_DEPTH);

    ofifo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .count     (count),
        .room      (room),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_raddr (ram_raddr),
        .issue     (issue)
    );

    ofifo_ram #(
        .WIDTH (DATA_W),
        .WORDS (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // results that skip the ram carry -1 when empty and 0 otherwise
    always_comb
    begin
        if (issue.use_ram)
        begin
            push_res.data = ram_rdata;
        end
        else if (issue.status == ST_EMPTY)
        begin
            push_res.data = '1;
        end
        else
        begin
            push_res.data = '0;
        end
        push_res.status = issue.status;
        push_res.last   = issue.last;
    end

    ofifo_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (issue.valid),
        .push_res  (push_res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res),
        .level     (level)
    );

    assign data   = out_res.data;
    assign status = out_res.status;
    assign last   = out_res.last;

endmodule

`default_nettype wire

>>> tb/overwriting_ring_fifo_checker.sv
`timescale 1ns / 1ps
// result checker for the overwriting ring fifo: watches both channels, keeps
// its own copy of the ring and compares every result word field by field
// depends on ofifo_pkg for widths, command and status codes and res_t

module overwriting_ring_fifo_checker
    import ofifo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [DATA_W-1:0] value,
    input  logic [COUNT_W-1:0]       count,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [DATA_W-1:0] data,
    input  logic [STATUS_W-1:0]      status,
    input  logic                     last,
    output int                       pending_words,
    output int                       mismatches
);

    logic signed [DATA_W-1:0] ring_store [DEPTH];
    logic [PTR_W-1:0]         oldest_ptr = '0;
    logic [PTR_W-1:0]         free_ptr = '0;
    logic [CNT_W-1:0]         held = '0;
    res_t                     expected_words [$];
    int                       error_total = 0;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    function automatic res_t make_word(input logic signed [DATA_W-1:0] d,
                                       input logic [STATUS_W-1:0] s, input logic l);
        res_t r;
        r.data = d;
        r.status = s;
        r.last = l;
        return r;
    endfunction

    // updates the ring copy for one accepted command and queues its result words
    task automatic predict_fifo_response(input logic [CMD_W-1:0] c,
                                         input logic signed [DATA_W-1:0] v,
                                         input logic [COUNT_W-1:0] n_req);
        int n;
        int idx;
        case (c)
            CMD_ENQ:
            begin
                if (int'(held) == DEPTH)
                begin
                    // full: the oldest word is dropped
                    oldest_ptr = wrap_inc(oldest_ptr);
                    expected_words.push_back(make_word('0, ST_OVERWRITE, 1'b1));
                end
                else
                begin
                    held = held + 1'b1;
                    expected_words.push_back(make_word('0, ST_OK, 1'b1));
                end
                ring_store[free_ptr] = v;
                free_ptr = wrap_inc(free_ptr);
            end
            CMD_DEQ:
            begin
                if (held == '0)
                    expected_words.push_back(make_word(-1, ST_EMPTY, 1'b1));
                else
                begin
                    expected_words.push_back(make_word(ring_store[oldest_ptr], ST_OK, 1'b1));
                    oldest_ptr = wrap_inc(oldest_ptr);
                    held = held - 1'b1;
                end
            end
            CMD_RDL:
            begin
                n = int'(n_req);
                if (n > RD_LIMIT)
                    n = RD_LIMIT;
                if (n > int'(held))
                    n = int'(held);
                if (n == 0)
                    expected_words.push_back(make_word(-1, ST_EMPTY, 1'b1));
                else
                begin
                    // newest n words, oldest of them first
                    idx = (int'(oldest_ptr) + int'(held) - n) % DEPTH;
                    for (int i = 0; i < n; i++)
                    begin
                        expected_words.push_back(make_word(ring_store[idx], ST_OK, i == n - 1));
                        idx = (idx + 1) % DEPTH;
                    end
                end
            end
            default:
            begin
                // unused command: no state change, no result
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_word;
        if (!rst_n)
        begin
            expected_words.delete();
            oldest_ptr = '0;
            free_ptr = '0;
            held = '0;
            pending_words <= 0;
            mismatches <= error_total;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: data %0d status %0d last %0d", data, status, last);
                    error_total++;
                end
                else
                begin
                    exp_word = expected_words.pop_front();
                    if (data !== exp_word.data)
                    begin
                        $error("data mismatch: expected %0d, got %0d", exp_word.data, data);
                        error_total++;
                    end
                    if (status !== exp_word.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d", exp_word.status, status);
                        error_total++;
                    end
                    if (last !== exp_word.last)
                    begin
                        $error("last mismatch: expected %0d, got %0d", exp_word.last, last);
                        error_total++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_fifo_response(cmd, value, count);
            pending_words <= expected_words.size();
            mismatches <= error_total;
        end
    end

endmodule

>>> tb/overwriting_ring_fifo_top_tb.sv
`timescale 1ns / 1ps
// testbench top for the overwriting ring fifo: drives commands with random
// gaps and back-pressure, fails on an idle timeout, else goes by the checker's count
// depends on ofifo_pkg, overwriting_ring_fifo_top and overwriting_ring_fifo_checker

module overwriting_ring_fifo_top_tb;
    import ofifo_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 280;
    localparam int PHASE_ITEMS  = 30;
    localparam int DRAIN_CYCLES = 20;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         cmd = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic [COUNT_W-1:0]       count = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic                     last;
    int                       pending_words;
    int                       mismatches;
    int                       idle_cycles = 0;
    bit                       steady = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    overwriting_ring_fifo_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .value     (value),
        .count     (count),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data      (data),
        .status    (status),
        .last      (last)
    );

    overwriting_ring_fifo_checker fifo_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .value         (value),
        .count         (count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data          (data),
        .status        (status),
        .last          (last),
        .pending_words (pending_words),
        .mismatches    (mismatches)
    );

    // mostly no gap, some short ones, a few long ones; none in steady stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v,
                             input logic [COUNT_W-1:0] n);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        value <= v;
        count <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // hold off the sender until every queued result word has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words != 0);
    endtask

    task automatic run_phase(input int enq_pct, input int deq_pct, inout int sent);
        int r;
        logic [CMD_W-1:0] c;
        logic [COUNT_W-1:0] n;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                c = CMD_UNUSED;
            else if (r < 3 + enq_pct)
                c = CMD_ENQ;
            else if (r < 3 + enq_pct + deq_pct)
                c = CMD_DEQ;
            else
                c = CMD_RDL;
            r = $urandom_range(0, 99);
            if (r < 6)
                n = '0;
            else if (r < 22)
                n = COUNT_W'($urandom_range(RD_LIMIT + 1, (1 << COUNT_W) - 1));
            else
                n = COUNT_W'($urandom_range(1, RD_LIMIT));
            send_word(c, $urandom, n);
            if (c != CMD_UNUSED)
                sent++;
        end
    endtask

    // result side: ready drops for random stretches
    initial
    begin
        int g;
        forever
        begin
            g = pick_gap();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("overwriting_ring_fifo_top regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int sent;
        int phase;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty fifo: dequeue and read-last, including a zero count
        send_word(CMD_DEQ, 32'sd0, 5'd1);
        send_word(CMD_RDL, 32'sd0, 5'd5);
        send_word(CMD_RDL, 32'sd0, 5'd0);
        // extreme values
        send_word(CMD_ENQ, 32'sh7fffffff, 5'd0);
        send_word(CMD_ENQ, 32'sh80000000, 5'd31);
        send_word(CMD_ENQ, 32'sd0, 5'd0);
        send_word(CMD_ENQ, -32'sd1, 5'd0);
        send_word(CMD_ENQ, 32'sh55555555, 5'd0);
        send_word(CMD_ENQ, 32'shaaaaaaaa, 5'd0);
        // counts above what is held and above the burst limit, then zero and two, two dequeues and an unused command
        send_word(CMD_RDL, 32'sd0, 5'd31);
        send_word(CMD_RDL, 32'sd0, 5'd17);
        send_word(CMD_RDL, 32'sd0, 5'd0);
        send_word(CMD_RDL, 32'sd0, 5'd2);
        send_word(CMD_DEQ, 32'sd0, 5'd0);
        send_word(CMD_DEQ, 32'sd0, 5'd0);
        send_word(CMD_UNUSED, 32'sh5a5a5a5a, 5'd31);
        // fill past full so the oldest words get overwritten, then dump all
        for (int i = 0; i < DEPTH - 2; i++)
            send_word(CMD_ENQ, $urandom, 5'd0);
        send_word(CMD_RDL, 32'sd0, 5'(DEPTH));
        wait_for_results();

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: run_phase(75, 12, sent);
                1: run_phase(15, 70, sent);
                2: run_phase(40, 30, sent);
                default: run_phase(35, 20, sent);
            endcase
            phase++;
            if (phase % 3 == 0)
                wait_for_results();
        end
        steady = 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("overwriting_ring_fifo_top regression: pass");
        else
            $display("overwriting_ring_fifo_top regression: fail");
        $finish;
    end

endmodule
